// File: hw/rtl/esv_pkg.sv
// Shared types and constants for the expression syntax validator.
// Holds character class codes, the queue item type and verdict codes.
// No dependencies.
package esv_pkg;

  // Deepest bracket nesting that is still legal
  localparam int MAX_DEPTH = 255;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  // Front-to-back queue size
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Character class codes
  localparam int CLS_W = 4;
  typedef logic [CLS_W-1:0] cls_t;

  localparam cls_t CL_BAD   = 4'd0;  // outside the allowed set
  localparam cls_t CL_X     = 4'd1;  // 'X'
  localparam cls_t CL_DIG   = 4'd2;  // '0'..'9'
  localparam cls_t CL_ADD   = 4'd3;  // '+'
  localparam cls_t CL_MINUS = 4'd4;  // '-'
  localparam cls_t CL_OPEN  = 4'd5;  // '('
  localparam cls_t CL_CLOSE = 4'd6;  // ')'
  localparam cls_t CL_CARET = 4'd7;  // '^'
  localparam cls_t CL_DOT   = 4'd8;  // '.'
  localparam cls_t CL_MUL   = 4'd9;  // '*', '/'

  // ASCII codes of interest
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Verdict codes
  localparam logic [1:0] V_OK       = 2'd0;
  localparam logic [1:0] V_BAD_CHAR = 2'd1;
  localparam logic [1:0] V_BAD_EXPR = 2'd2;

  // One classified character in the queue
  typedef struct packed {
    cls_t cls;
    logic last;
  } item_t;

endpackage

// File: hw/rtl/expression_syntax_validator.sv
// Expression syntax validator: one character beat per cycle while the queue has room, one verdict per formula.
// The verdict follows the beat with tlast through the queue write, then the back end's
// verdict register.
// Throughput: one character per cycle while the verdict register is free or draining; the rule check is combinational.
// Reset (rst, synchronous): empties the queue, clears formula state and verdict valid.
// Depends on esv_pkg, esv_front, esv_queue and esv_back.
module expression_syntax_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] verdict, [7:2] zero
);

  esv_pkg::item_t push_item;
  esv_pkg::item_t head;
  logic           push;
  logic           pop;
  logic           full;
  logic           not_empty;

  // Accept and classify
  esv_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (full),
    .q_push   (push),
    .q_item   (push_item)
  );

  // Decoupling queue
  esv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // Rule checks and verdict
  esv_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_head   (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: hw/rtl/esv_front.sv
// Front end: accepts character beats and classifies them.
// Pushes classified items into the queue; depends on esv_pkg.
module esv_front (
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,   // [7:0] ch
  input  logic           s_tlast,
  input  logic           q_full,
  output logic           q_push,
  output esv_pkg::item_t q_item
);

  // Character classifier
  function automatic esv_pkg::cls_t classify(input logic [7:0] c);
    esv_pkg::cls_t r;
    r = esv_pkg::CL_BAD;
    if (c >= esv_pkg::CH_0 && c <= esv_pkg::CH_9) begin
      r = esv_pkg::CL_DIG;
    end else begin
      case (c)
        esv_pkg::CH_X:     r = esv_pkg::CL_X;
        esv_pkg::CH_PLUS:  r = esv_pkg::CL_ADD;
        esv_pkg::CH_STAR:  r = esv_pkg::CL_MUL;
        esv_pkg::CH_SLASH: r = esv_pkg::CL_MUL;
        esv_pkg::CH_MINUS: r = esv_pkg::CL_MINUS;
        esv_pkg::CH_OPEN:  r = esv_pkg::CL_OPEN;
        esv_pkg::CH_CLOSE: r = esv_pkg::CL_CLOSE;
        esv_pkg::CH_CARET: r = esv_pkg::CL_CARET;
        esv_pkg::CH_DOT:   r = esv_pkg::CL_DOT;
        default:           r = esv_pkg::CL_BAD;
      endcase
    end
    return r;
  endfunction

  // Accept whenever the queue has room
  assign s_tready    = !q_full;
  assign q_push      = s_tvalid && !q_full;
  assign q_item.cls  = classify(s_tdata);
  assign q_item.last = s_tlast;

endmodule

// File: hw/rtl/esv_queue.sv
// Short FIFO of classified items between front and back.
// Depends on esv_pkg for the item type and depth.
module esv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  esv_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output esv_pkg::item_t head
);

  esv_pkg::item_t             slots [esv_pkg::QDEPTH];
  logic [esv_pkg::QAW-1:0]    wr_ptr;
  logic [esv_pkg::QAW-1:0]    rd_ptr;
  logic [esv_pkg::QAW:0]      count;

  assign full      = (count == (esv_pkg::QAW+1)'(esv_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + esv_pkg::QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + esv_pkg::QAW'(1);
      if (push && !pop)      count <= count + (esv_pkg::QAW+1)'(1);
      else if (pop && !push) count <= count - (esv_pkg::QAW+1)'(1);
    end
  end

endmodule

// File: hw/rtl/esv_back.sv
// Back end: neighbor rules, bracket depth and the verdict register.
// Pops classified items from the queue; depends on esv_pkg.
module esv_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  esv_pkg::item_t q_head,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata    // [1:0] verdict, [7:2] zero
);

  esv_pkg::cls_t                prev_cls;
  esv_pkg::cls_t                prev_prev_cls;
  logic [1:0]                   seen_count;
  logic [esv_pkg::DEPTH_W-1:0]  depth;
  logic                         syntax_bad;
  logic                         charset_bad;
  logic [1:0]                   verdict;

  logic [esv_pkg::DEPTH_W-1:0]  depth_next;
  logic                         syntax_bad_next;
  logic                         charset_bad_next;
  logic                         can_take;
  esv_pkg::cls_t                c;

  function automatic logic is_op(input esv_pkg::cls_t k);
    return k == esv_pkg::CL_ADD || k == esv_pkg::CL_MINUS || k == esv_pkg::CL_MUL;
  endfunction

  function automatic logic is_dig(input esv_pkg::cls_t k);
    return k == esv_pkg::CL_DIG;
  endfunction

  // Inner character check: b before, m middle, a after
  function automatic logic inner_ok(input esv_pkg::cls_t b, input esv_pkg::cls_t m,
                                    input esv_pkg::cls_t a);
    logic r;
    r = 1'b1;
    unique case (m) inside
      esv_pkg::CL_X: begin
        // of the operators, only '+' and '-' may lead into X, not '*' or '/'
        r = b == esv_pkg::CL_ADD || b == esv_pkg::CL_MINUS ||
            b == esv_pkg::CL_OPEN || b == esv_pkg::CL_CARET || is_dig(b);
        r = r && (a == esv_pkg::CL_CARET || is_op(a) || a == esv_pkg::CL_CLOSE);
      end
      esv_pkg::CL_ADD, esv_pkg::CL_MINUS, esv_pkg::CL_MUL: begin
        r = (b == esv_pkg::CL_X || b == esv_pkg::CL_CLOSE || is_dig(b) ||
             (m == esv_pkg::CL_MINUS && b == esv_pkg::CL_CARET)) &&
            (a == esv_pkg::CL_X || a == esv_pkg::CL_OPEN || is_dig(a));
      end
      esv_pkg::CL_OPEN: begin
        r = (b == esv_pkg::CL_CARET || is_op(b)) &&
            (a == esv_pkg::CL_X || is_dig(a));
      end
      esv_pkg::CL_CLOSE: begin
        r = (b == esv_pkg::CL_X || is_dig(b)) &&
            (a == esv_pkg::CL_CARET || is_op(a));
      end
      esv_pkg::CL_CARET: begin
        r = (b == esv_pkg::CL_CLOSE || b == esv_pkg::CL_X || is_dig(b)) &&
            (a == esv_pkg::CL_OPEN || a == esv_pkg::CL_X ||
             a == esv_pkg::CL_MINUS || is_dig(a));
      end
      esv_pkg::CL_DOT: begin
        r = is_dig(b) && is_dig(a);
      end
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  // Take an item when the verdict register is free or draining
  assign can_take = !m_tvalid || m_tready;
  assign q_pop    = q_valid && can_take;
  assign c        = q_head.cls;
  assign m_tdata  = {6'b0, verdict};

  // Rule checks and depth update for the item at the queue head
  always_comb begin
    charset_bad_next = charset_bad || (c == esv_pkg::CL_BAD);
    syntax_bad_next  = syntax_bad;
    depth_next       = depth;
    if (seen_count == 2'd0) begin
      if (!(c == esv_pkg::CL_X || c == esv_pkg::CL_OPEN || is_dig(c)))
        syntax_bad_next = 1'b1;
    end else if (seen_count == 2'd2) begin
      if (!inner_ok(prev_prev_cls, prev_cls, c)) syntax_bad_next = 1'b1;
    end
    if (c == esv_pkg::CL_OPEN) begin
      if (depth >= esv_pkg::DEPTH_W'(esv_pkg::MAX_DEPTH)) syntax_bad_next = 1'b1;
      else depth_next = depth + esv_pkg::DEPTH_W'(1);
    end else if (c == esv_pkg::CL_CLOSE) begin
      if (depth == '0) syntax_bad_next = 1'b1;
      else depth_next = depth - esv_pkg::DEPTH_W'(1);
    end
    if (q_head.last) begin
      if (!(c == esv_pkg::CL_CLOSE || c == esv_pkg::CL_X || is_dig(c)))
        syntax_bad_next = 1'b1;
      if (depth_next != '0) syntax_bad_next = 1'b1;
    end
  end

  // Formula state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cls      <= esv_pkg::CL_BAD;
      prev_prev_cls <= esv_pkg::CL_BAD;
      seen_count    <= '0;
      depth         <= '0;
      syntax_bad    <= 1'b0;
      charset_bad   <= 1'b0;
    end else if (q_pop) begin
      if (q_head.last) begin
        prev_cls      <= esv_pkg::CL_BAD;
        prev_prev_cls <= esv_pkg::CL_BAD;
        seen_count    <= '0;
        depth         <= '0;
        syntax_bad    <= 1'b0;
        charset_bad   <= 1'b0;
      end else begin
        prev_prev_cls <= prev_cls;
        prev_cls      <= c;
        if (seen_count != 2'd2) seen_count <= seen_count + 2'd1;
        depth       <= depth_next;
        syntax_bad  <= syntax_bad_next;
        charset_bad <= charset_bad_next;
      end
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop && q_head.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      verdict <= charset_bad_next ? esv_pkg::V_BAD_CHAR :
                 (syntax_bad_next ? esv_pkg::V_BAD_EXPR : esv_pkg::V_OK);
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench for expression_syntax_validator: streams formulas in and checks each verdict.
// A checker class predicts the verdict per formula; tasks drive the input side, an initial block the ready.
// Depends on esv_pkg and the expression_syntax_validator RTL.
module tb_top;

  localparam int LIMIT       = 400000;  // cycles before the run is declared hung
  localparam int SHORT_ITEMS = 1700;    // characters in the random short-formula phase
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;

  expression_syntax_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] ch
    .s_tlast  (s_tlast),   // last
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [1:0] verdict, [7:2] zero
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tracks one formula at a time and queues the verdict each final character earns
  class formula_checker;
    logic [7:0]  back1;
    logic [7:0]  back2;
    logic [1:0]  seen;
    int unsigned nest;
    bit          syn_err;
    bit          chr_err;
    logic [1:0]  verdicts_due[$];
    int          fails;

    function new();
      clear();
      fails = 0;
    endfunction

    function void clear();
      back1   = 8'h00;
      back2   = 8'h00;
      seen    = 2'd0;
      nest    = 0;
      syn_err = 1'b0;
      chr_err = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= esv_pkg::CH_0 && c <= esv_pkg::CH_9;
    endfunction

    function bit is_arith(logic [7:0] c);
      return c == esv_pkg::CH_PLUS || c == esv_pkg::CH_MINUS ||
             c == esv_pkg::CH_STAR || c == esv_pkg::CH_SLASH;
    endfunction

    function bit legal(logic [7:0] c);
      return c == esv_pkg::CH_X || is_arith(c) || c == esv_pkg::CH_CARET ||
             c == esv_pkg::CH_OPEN || c == esv_pkg::CH_CLOSE || c == esv_pkg::CH_DOT ||
             is_digit(c);
    endfunction

    // Neighbor rule for the middle character c, with b before and a after
    function bit inner_ok(logic [7:0] b, logic [7:0] c, logic [7:0] a);
      if (c == esv_pkg::CH_X)
        return (b == esv_pkg::CH_PLUS || b == esv_pkg::CH_MINUS ||
                b == esv_pkg::CH_OPEN || b == esv_pkg::CH_CARET || is_digit(b)) &&
               (a == esv_pkg::CH_CARET || is_arith(a) || a == esv_pkg::CH_CLOSE);
      if (is_arith(c))
        return (b == esv_pkg::CH_X || b == esv_pkg::CH_CLOSE || is_digit(b) ||
                (c == esv_pkg::CH_MINUS && b == esv_pkg::CH_CARET)) &&
               (a == esv_pkg::CH_X || a == esv_pkg::CH_OPEN || is_digit(a));
      if (c == esv_pkg::CH_OPEN)
        return (b == esv_pkg::CH_CARET || is_arith(b)) &&
               (a == esv_pkg::CH_X || is_digit(a));
      if (c == esv_pkg::CH_CLOSE)
        return (b == esv_pkg::CH_X || is_digit(b)) &&
               (a == esv_pkg::CH_CARET || is_arith(a));
      if (c == esv_pkg::CH_CARET)
        return (b == esv_pkg::CH_CLOSE || b == esv_pkg::CH_X || is_digit(b)) &&
               (a == esv_pkg::CH_OPEN || a == esv_pkg::CH_X ||
                a == esv_pkg::CH_MINUS || is_digit(a));
      if (c == esv_pkg::CH_DOT)
        return is_digit(b) && is_digit(a);
      return 1'b1;
    endfunction

    function void take_char(logic [7:0] ch, logic last);
      if (!legal(ch))
        chr_err = 1'b1;
      // first-character rule, else neighbor rule for the character one back
      if (seen == 2'd0) begin
        if (!(ch == esv_pkg::CH_X || ch == esv_pkg::CH_OPEN || is_digit(ch)))
          syn_err = 1'b1;
      end else if (seen == 2'd2 && !inner_ok(back2, back1, ch)) begin
        syn_err = 1'b1;
      end
      // bracket depth, clamped at both ends
      if (ch == esv_pkg::CH_OPEN) begin
        if (nest >= esv_pkg::MAX_DEPTH)
          syn_err = 1'b1;
        else
          nest++;
      end else if (ch == esv_pkg::CH_CLOSE) begin
        if (nest == 0)
          syn_err = 1'b1;
        else
          nest--;
      end
      if (last) begin
        if (!(ch == esv_pkg::CH_CLOSE || ch == esv_pkg::CH_X || is_digit(ch)))
          syn_err = 1'b1;
        if (nest != 0)
          syn_err = 1'b1;
        verdicts_due.push_back(chr_err ? esv_pkg::V_BAD_CHAR :
                               (syn_err ? esv_pkg::V_BAD_EXPR : esv_pkg::V_OK));
        clear();
        return;
      end
      back2 = back1;
      back1 = ch;
      if (seen != 2'd2)
        seen++;
    endfunction

    function void match_verdict(logic [7:0] beat);
      logic [7:0] want;
      if (verdicts_due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected verdict beat %02h", beat);
        return;
      end
      want = {6'b0, verdicts_due.pop_front()};
      if (beat !== want) begin
        fails++;
        if (fails <= 10)
          $display("verdict mismatch: expected %02h, got %02h", want, beat);
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  formula_checker chk = new();

  logic [7:0]  formula[$];
  int          burst_left = 0;
  int          short_items = 0;
  int          formulas = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned cycles = 0;

  // ---------------------------------------------------------------------------
  // Formula builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return esv_pkg::CH_PLUS;
      1:       return esv_pkg::CH_MINUS;
      2:       return esv_pkg::CH_STAR;
      default: return esv_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return esv_pkg::CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_leaf();
    return $urandom_range(0, 1) ? esv_pkg::CH_X : pick_digit();
  endfunction

  function automatic logic [7:0] any_legal();
    case ($urandom_range(0, 9))
      0:       return esv_pkg::CH_X;
      1, 2, 3: return pick_digit();
      4, 5:    return pick_op();
      6:       return esv_pkg::CH_CARET;
      7:       return esv_pkg::CH_DOT;
      8:       return esv_pkg::CH_OPEN;
      default: return esv_pkg::CH_CLOSE;
    endcase
  endfunction

  function automatic void add_atom(int lvl);
    int pick = $urandom_range(0, (lvl > 0) ? 2 : 1);
    int nd = $urandom_range(1, 3);
    case (pick)
      0: formula.push_back(esv_pkg::CH_X);
      1: begin
        repeat (nd) formula.push_back(pick_digit());
        if ($urandom_range(0, 3) == 0) begin
          formula.push_back(esv_pkg::CH_DOT);
          formula.push_back(pick_digit());
        end
      end
      default: begin
        formula.push_back(esv_pkg::CH_OPEN);
        add_expr(lvl - 1);
        formula.push_back(esv_pkg::CH_CLOSE);
      end
    endcase
  endfunction

  // atom, optionally raised to a power that may be negated
  function automatic void add_term(int lvl);
    add_atom(lvl);
    if ($urandom_range(0, 3) == 0) begin
      formula.push_back(esv_pkg::CH_CARET);
      if ($urandom_range(0, 1))
        formula.push_back(esv_pkg::CH_MINUS);
      add_atom(lvl);
    end
  endfunction

  function automatic void add_expr(int lvl);
    int terms = $urandom_range(0, 2);
    add_term(lvl);
    repeat (terms) begin
      formula.push_back(pick_op());
      add_term(lvl);
    end
  endfunction

  // Mostly well-formed formulas; some get one character corrupted, dropped or
  // inserted, and a few are pure noise
  function automatic void make_formula();
    int kind = $urandom_range(0, 9);
    int len = $urandom_range(1, 6);
    int pos;
    formula.delete();
    if (kind == 9) begin
      repeat (len)
        formula.push_back($urandom_range(0, 1) ? any_legal() : 8'($urandom_range(0, 255)));
      return;
    end
    add_expr(2);
    pos = $urandom_range(0, formula.size() - 1);
    case (kind)
      6: formula[pos] = 8'($urandom_range(0, 255));
      7: formula[pos] = any_legal();
      8: begin
        if (formula.size() > 1)
          formula.delete(pos);
        else
          formula.insert(pos, any_legal());
      end
      default: ;
    endcase
  endfunction

  // Legal nesting needs an operator before each open and after each close:
  // (a op (a op ( ... a) op a) op a)
  function automatic void make_deep(int levels);
    formula.delete();
    formula.push_back(esv_pkg::CH_OPEN);
    formula.push_back(pick_leaf());
    repeat (levels - 1) begin
      formula.push_back($urandom_range(0, 4) == 0 ? esv_pkg::CH_CARET : pick_op());
      formula.push_back(esv_pkg::CH_OPEN);
      formula.push_back(pick_leaf());
    end
    formula.push_back(esv_pkg::CH_CLOSE);
    repeat (levels - 1) begin
      formula.push_back($urandom_range(0, 4) == 0 ? esv_pkg::CH_CARET : pick_op());
      formula.push_back(pick_leaf());
      formula.push_back(esv_pkg::CH_CLOSE);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: bursts of beats with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_char(logic [7:0] ch, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    chk.take_char(ch, last);
  endtask

  task automatic send_formula();
    for (int i = 0; i < formula.size(); i++)
      send_char(formula[i], i == formula.size() - 1);
  endtask

  task automatic send_text(string s);
    formula.delete();
    for (int i = 0; i < s.len(); i++)
      formula.push_back(s[i]);
    send_formula();
  endtask

  // Main stimulus
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tlast  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: single characters, extremes, every operator, bracket errors,
    // negated power, decimal point, bad character amid a syntax error
    send_text("X");
    send_text("9");
    formula = '{8'h00};
    send_formula();
    formula = '{8'hFF};
    send_formula();
    send_text("(");
    send_text("(X)");
    send_text("X^-1");
    send_text("0.5/X");
    send_text("2*X+1");
    send_text(")X");
    send_text("X@)");

    // random formulas, with the two nesting limits dropped in along the way
    while (short_items < SHORT_ITEMS) begin
      if (formulas == 20)
        hold_req = 1'b1;
      if (formulas == 40) begin
        make_deep(esv_pkg::MAX_DEPTH);
        send_formula();
      end
      if (formulas == 80) begin
        make_deep(esv_pkg::MAX_DEPTH + 1);
        send_formula();
      end
      make_formula();
      short_items += formula.size();
      send_formula();
      formulas++;
    end
    s_tvalid <= 1'b0;

    // drain, then allow for the output pipeline
    while (chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (chk.fails == 0)
      $display("PASS expression_syntax_validator");
    else
      $display("FAIL expression_syntax_validator");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: ready pattern switches among four modes at random; one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int tick;
    mode = 0;
    tick = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      tick++;
      if (tick % 64 == 0)
        mode = $urandom_range(0, 3);
      case (mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= (tick % 5 != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Verdict check on every accepted output beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      chk.match_verdict(m_tdata);
  end

  // Hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL expression_syntax_validator");
      $finish;
    end
  end

endmodule
